>>> sv/sha_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies; imported by the controller, the datapath and the top level.
package sha_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;     // place in_data_byte at the current byte position
    logic pad_byte;      // place 0x80 at the current byte position
    logic put_len;       // write the bit length into words 14 and 15
    logic start_comp;    // load schedule and working vars from buffer and chain
    logic round_en;      // run one compression round
    logic finish_comp;   // add working vars into chain, clear buffer
    logic reinit;        // restore initial hash, clear length and position
    logic bump_len;      // count one message byte
  } sha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       block_full;  // byte position at 63, so a write here fills the block
    logic       pos_over56;  // byte position after a write here above 56
    logic [5:0] round_idx;
  } sha_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> sv/sha_ctrl.sv
// Sequencer for the SHA-256 hasher: byte intake, padding, rounds and digest beats.
// Depends on sha_pkg.
module sha_ctrl
  import sha_pkg::*;
#(
  parameter int ROUNDS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_byte_valid,
  input  logic      in_last_item,
  input  sha_stat_t stat,
  output sha_cmd_t  cmd,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [2:0] out_idx
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_LEN   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // Where to go after a compression finishes.
  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_PAD  = 2'd1;
  localparam logic [1:0] RET_LEN  = 2'd2;
  localparam logic [1:0] RET_OUT  = 2'd3;

  logic [2:0] state_r, state_nxt;
  logic [1:0] ret_r, ret_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign acc       = in_valid && (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_idx   = idx_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd.take_byte = in_byte_valid;
          cmd.bump_len  = in_byte_valid;
          if (in_byte_valid && stat.block_full) begin
            cmd.start_comp = 1'b1;
            state_nxt      = ST_ROUND;
            ret_nxt        = in_last_item ? RET_PAD : RET_IDLE;
          end else if (in_last_item) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.pad_byte = 1'b1;
        if (stat.block_full || stat.pos_over56) begin
          cmd.start_comp = 1'b1;
          state_nxt      = ST_ROUND;
          ret_nxt        = RET_LEN;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.put_len    = 1'b1;
        cmd.start_comp = 1'b1;
        state_nxt      = ST_ROUND;
        ret_nxt        = RET_OUT;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round_idx == 6'(ROUNDS - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish_comp = 1'b1;
        case (ret_r)
          RET_PAD:  state_nxt = ST_PAD;
          RET_LEN:  state_nxt = ST_LEN;
          RET_OUT:  begin
            state_nxt = ST_OUT;
            idx_nxt   = '0;
          end
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.reinit = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= RET_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> sv/sha_dp.sv
// Datapath for the SHA-256 hasher: block buffer, schedule window, round logic, chain.
// Depends on sha_pkg.
module sha_dp
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sha_cmd_t    cmd,
  input  logic [7:0]  in_data_byte,
  input  logic [2:0]  out_idx,
  output sha_stat_t   stat,
  output logic [31:0] out_digest_word
);

  logic [31:0] buf_r [16];
  logic [31:0] w_r   [16];
  logic [31:0] v_r   [8];
  logic [31:0] h_r   [8];
  logic [5:0]  pos_r;
  logic [5:0]  rnd_r;
  logic [60:0] len_r;

  logic [7:0]  wr_byte;
  logic [5:0]  pos_inc;
  logic [31:0] w_new, wt, t1, t2;

  assign wr_byte = cmd.pad_byte ? PAD_BYTE : in_data_byte;
  assign pos_inc = pos_r + 6'd1;

  assign stat.block_full = (pos_r == 6'd63);
  assign stat.pos_over56 = (pos_inc > 6'd56);
  assign stat.round_idx  = rnd_r;

  assign out_digest_word = h_r[out_idx];

  // Schedule word: from round 16 on the window holds W[t-16..t-1] with w_r[0] oldest.
  assign w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign wt    = (rnd_r < 6'd16) ? w_r[rnd_r[3:0]] : w_new;

  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + ROUND_K[rnd_r] + wt;
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // Control-side registers: position, length, round count, chain.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      pos_r <= '0;
      len_r <= '0;
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[i];
    end else begin
      if (cmd.take_byte || cmd.pad_byte) pos_r <= pos_inc;
      else if (cmd.put_len)              pos_r <= '0;
      if (cmd.bump_len) len_r <= len_r + 61'd1;
      if (cmd.start_comp)    rnd_r <= '0;
      else if (cmd.round_en) rnd_r <= rnd_r + 6'd1;
      if (cmd.finish_comp)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  // Block buffer: byte writes, length words, clear after compression.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit || cmd.finish_comp) begin
      for (int i = 0; i < 16; i++) buf_r[i] <= '0;
    end else begin
      if (cmd.take_byte || cmd.pad_byte)
        buf_r[pos_r[5:2]][8*(3-pos_r[1:0]) +: 8] <= wr_byte;
      if (cmd.put_len) begin
        buf_r[14] <= {len_r[60:29]};
        buf_r[15] <= {len_r[28:0], 3'b000};
      end
    end
  end

  // Schedule window and working variables.
  always_ff @(posedge clk) begin
    if (cmd.start_comp) begin
      for (int i = 0; i < 16; i++) w_r[i] <= (cmd.put_len && i == 14) ? len_r[60:29] :
                                            (cmd.put_len && i == 15) ? {len_r[28:0], 3'b000} :
                                            (cmd.pad_byte && i == int'(pos_r[5:2]))
                                              ? (buf_r[i] | ({24'd0, PAD_BYTE}
                                                 << (8*(3-pos_r[1:0]))))
                                            : (cmd.take_byte && i == int'(pos_r[5:2]))
                                              ? (buf_r[i] | ({24'd0, in_data_byte}
                                                 << (8*(3-pos_r[1:0]))))
                                            : buf_r[i];
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round_en) begin
      if (rnd_r >= 6'd16) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
      end
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule

>>> sv/sha256_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher: controller plus datapath.
// Depends on sha_pkg, sha_ctrl and sha_dp.
//
//  channel  | ports                                        | direction
//  in       | in_valid, in_stall, in_data_byte,            | byte beats in
//           | in_byte_valid, in_last_item                  |
//  out      | out_valid, out_stall, out_digest_word,       | digest beats out
//           | out_word_index, out_last_word                |
//
// A plain byte beat is taken without a stall; a beat that fills a block also starts
// a compression (the rounds of the single round unit, then the chain add; the load
// shares the accepting cycle). A last beat runs one or two padded blocks, after a
// compression of the filled block when its byte also fills one, then 8 output beats.
// Reset is synchronous on rst_n and restores the initial hash at once.
// in_stall is high whenever the sequencer is busy; out_stall holds a word.
module sha256_stream_hasher_core
  import sha_pkg::*;
#(
  parameter int ROUNDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic [2:0] idx;

  sha_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte_valid(in_byte_valid), .in_last_item(in_last_item),
    .stat(stat), .cmd(cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_idx(idx)
  );

  sha_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_data_byte(in_data_byte), .out_idx(idx),
    .stat(stat), .out_digest_word(out_digest_word)
  );

  assign out_word_index = idx;
  assign out_last_word  = (idx == 3'd7);

endmodule
